// ----- hdl/fiq_pkg.sv -----
// shared types, widths and helpers for the fp32 to int8 weight quantizer
// no dependencies
`timescale 1ns / 1ps

package fiq_pkg;

    localparam int FP_W      = 32;
    localparam int MANT_W    = 24;
    localparam int EXP_W     = 8;
    localparam int Q_W       = 8;
    localparam int LZ_W      = 5;
    localparam int PROD_W    = 2 * MANT_W;
    // fixed point sum: 10 integer bits, 25 fraction bits
    localparam int FRAC_W    = 25;
    localparam int SUM_W     = 35;
    localparam int ULP_W     = 4;
    localparam int XEXP_W    = 11;
    localparam logic [EXP_W-1:0] EXP_MAX = '1;
    localparam logic [FP_W-1:0]  SCALE_RESET = '0;

    typedef struct packed {
        logic sign;
        logic nan;
        logic ovf;   // magnitude at least 256 or infinite
        logic zero;  // magnitude too small to reach one after rounding
    } fiq_ctl_t;

    function automatic logic [LZ_W-1:0] lzc24(input logic [MANT_W-1:0] m);
        logic [LZ_W-1:0] n;
        logic            found;
        n     = '0;
        found = 1'b0;
        for (int i = MANT_W - 1; i >= 0; i--) begin
            if (!found && m[i]) begin
                found = 1'b1;
                n     = LZ_W'(MANT_W - 1 - i);
            end
        end
        return n;
    endfunction

endpackage

// ----- hdl/fp32_to_int8_weight_quantizer.sv -----
// fp32 weight times fp32 scale, round half away, clamp to int8, seven stage pipeline
// depends on fiq_pkg
`timescale 1ns / 1ps

// channel   direction  payload (low bit first)
// s_        in         tdata: weight_bits[31:0]
// m_        out        tdata: quantized_value[7:0]; tuser: saturated, not_a_number
// cfg       in         weight_scale_we, weight_scale_wdata[31:0]
//
// one weight per cycle while the output register is empty or taken
// stages: unpack, normalize, multiply, round product, add half, find msb, round and clamp
// the whole pipeline advances when the output register is empty or taken
// reset clears valid bits and sets the scale to +0.0
module fp32_to_int8_weight_quantizer #(
    parameter logic [fiq_pkg::FP_W-1:0] SCALE_RESET = fiq_pkg::SCALE_RESET
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      weight_scale_we,
    input  logic [fiq_pkg::FP_W-1:0]  weight_scale_wdata,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [fiq_pkg::FP_W-1:0]  s_tdata,   // weight_bits
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [fiq_pkg::Q_W-1:0]   m_tdata,   // quantized_value
    output logic [1:0]                m_tuser    // saturated, not_a_number
);

    localparam int NSTG = 7;

    logic                     adv;
    logic [NSTG-1:0]          valid_reg;
    logic [fiq_pkg::FP_W-1:0] scale_reg;

    assign adv      = !valid_reg[NSTG-1] || m_tready;
    assign s_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg <= SCALE_RESET;
        end else if (weight_scale_we) begin
            scale_reg <= weight_scale_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= {valid_reg[NSTG-2:0], s_tvalid};
        end
    end

    // stage 1: unpack
    logic [fiq_pkg::MANT_W-1:0] m1w_next, m1s_next, m1w_reg, m1s_reg;
    logic [fiq_pkg::EXP_W-1:0]  e1w_next, e1s_next, e1w_reg, e1s_reg;
    logic [fiq_pkg::LZ_W-1:0]   lz1w_reg, lz1s_reg;
    fiq_pkg::fiq_ctl_t          c1_next, c1_reg;

    always_comb begin
        logic [fiq_pkg::EXP_W-1:0] ew, es;
        logic                      nw, ns, iw, is_, zw, zs;
        ew       = s_tdata[30:23];
        es       = scale_reg[30:23];
        m1w_next = {ew != '0, s_tdata[22:0]};
        m1s_next = {es != '0, scale_reg[22:0]};
        e1w_next = (ew == '0) ? fiq_pkg::EXP_W'(1) : ew;
        e1s_next = (es == '0) ? fiq_pkg::EXP_W'(1) : es;
        nw  = (ew == fiq_pkg::EXP_MAX) && (s_tdata[22:0] != '0);
        ns  = (es == fiq_pkg::EXP_MAX) && (scale_reg[22:0] != '0);
        iw  = (ew == fiq_pkg::EXP_MAX) && (s_tdata[22:0] == '0);
        is_ = (es == fiq_pkg::EXP_MAX) && (scale_reg[22:0] == '0);
        zw  = (ew == '0) && (s_tdata[22:0] == '0);
        zs  = (es == '0) && (scale_reg[22:0] == '0);
        c1_next.sign = s_tdata[31] ^ scale_reg[31];
        c1_next.nan  = nw || ns || (iw && zs) || (is_ && zw);
        c1_next.ovf  = iw || is_;
        c1_next.zero = zw || zs;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m1w_reg  <= m1w_next;
            m1s_reg  <= m1s_next;
            e1w_reg  <= e1w_next;
            e1s_reg  <= e1s_next;
            lz1w_reg <= fiq_pkg::lzc24(m1w_next);
            lz1s_reg <= fiq_pkg::lzc24(m1s_next);
            c1_reg   <= c1_next;
        end
    end

    // stage 2: normalize subnormal operands
    logic [fiq_pkg::MANT_W-1:0]        m2w_reg, m2s_reg;
    logic signed [fiq_pkg::XEXP_W-1:0] e2w_reg, e2s_reg;
    fiq_pkg::fiq_ctl_t                 c2_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            m2w_reg <= m1w_reg << lz1w_reg;
            m2s_reg <= m1s_reg << lz1s_reg;
            e2w_reg <= $signed({3'b000, e1w_reg}) - $signed({6'b0, lz1w_reg});
            e2s_reg <= $signed({3'b000, e1s_reg}) - $signed({6'b0, lz1s_reg});
            c2_reg  <= c1_reg;
        end
    end

    // stage 3: significand multiply
    logic [fiq_pkg::PROD_W-1:0]        p3_reg;
    logic signed [fiq_pkg::XEXP_W-1:0] e3_reg;
    fiq_pkg::fiq_ctl_t                 c3_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            p3_reg <= m2w_reg * m2s_reg;
            e3_reg <= e2w_reg + e2s_reg;
            c3_reg <= c2_reg;
        end
    end

    // stage 4: round product to 24 bits, value = rp * 2^(x-23)
    logic [fiq_pkg::MANT_W:0]          rp4_next, rp4_reg;
    logic signed [fiq_pkg::XEXP_W-1:0] x4_next, x4_reg;
    fiq_pkg::fiq_ctl_t                 c4_reg;

    always_comb begin
        logic [fiq_pkg::MANT_W-1:0] p;
        logic                       g, st;
        if (p3_reg[47]) begin
            p  = p3_reg[47:24];
            g  = p3_reg[23];
            st = |p3_reg[22:0];
        end else begin
            p  = p3_reg[46:23];
            g  = p3_reg[22];
            st = |p3_reg[21:0];
        end
        rp4_next = {1'b0, p} + {24'd0, g && (st || p[0])};
        x4_next  = e3_reg - fiq_pkg::XEXP_W'(254) + {10'd0, p3_reg[47]};
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rp4_reg <= rp4_next;
            x4_reg  <= x4_next;
            c4_reg  <= c3_reg;
        end
    end

    // stage 5: to fixed point with 25 fraction bits, add one half
    logic [fiq_pkg::SUM_W-1:0] s5_next, s5_reg;
    fiq_pkg::fiq_ctl_t         c5_next, c5_reg;

    always_comb begin
        logic [fiq_pkg::SUM_W-1:0] f;
        logic [3:0]                sh;
        logic                      tiny, big;
        tiny  = x4_reg < -2;
        big   = x4_reg > 7;
        sh    = 4'(x4_reg + 2);
        f     = (tiny || big) ? '0 : ({10'd0, rp4_reg} << sh);
        s5_next = f + (fiq_pkg::SUM_W'(1) << (fiq_pkg::FRAC_W - 1));
        c5_next      = c4_reg;
        c5_next.ovf  = c4_reg.ovf || (big && !c4_reg.zero);
        // an infinite operand stays infinite however tiny the other one is
        c5_next.zero = c4_reg.zero || (tiny && !c4_reg.ovf);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s5_reg <= s5_next;
            c5_reg <= c5_next;
        end
    end

    // stage 6: position of the rounding bit for a 24 bit significand
    logic [fiq_pkg::ULP_W-1:0] u6_next, u6_reg;
    logic [fiq_pkg::SUM_W-1:0] s6_reg;
    fiq_pkg::fiq_ctl_t         c6_reg;

    always_comb begin
        u6_next = fiq_pkg::ULP_W'(1);
        for (int k = 24; k < fiq_pkg::SUM_W; k++) begin
            if (s5_reg[k]) begin
                u6_next = fiq_pkg::ULP_W'(k - 23);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            u6_reg <= u6_next;
            s6_reg <= s5_reg;
            c6_reg <= c5_reg;
        end
    end

    // stage 7: round to nearest even, truncate, clamp
    logic [fiq_pkg::Q_W-1:0] q7_next, q7_reg;
    logic                    sat7_next, sat7_reg, nan7_reg;

    always_comb begin
        logic [fiq_pkg::SUM_W-1:0] unit, mask, lower, half, rs;
        logic [9:0]                ip;
        logic                      up, fr;
        unit  = fiq_pkg::SUM_W'(1) << u6_reg;
        mask  = unit - fiq_pkg::SUM_W'(1);
        half  = unit >> 1;
        lower = s6_reg & mask;
        up    = (lower > half) || ((lower == half) && ((s6_reg & unit) != '0));
        rs    = (s6_reg & ~mask) + (up ? unit : '0);
        ip    = rs[34:25];
        fr    = |rs[24:0];
        q7_next   = '0;
        sat7_next = 1'b0;
        if (c6_reg.nan || c6_reg.zero) begin
            q7_next   = '0;
            sat7_next = 1'b0;
        end else if (!c6_reg.sign) begin
            if (c6_reg.ovf || ip > 10'd127 || (ip == 10'd127 && fr)) begin
                q7_next   = 8'sd127;
                sat7_next = c6_reg.ovf || ip > 10'd127 || fr;
            end else begin
                q7_next = ip[7:0];
            end
        end else begin
            if (c6_reg.ovf || ip > 10'd128 || (ip == 10'd128 && fr)) begin
                q7_next   = 8'h80;
                sat7_next = 1'b1;
            end else begin
                q7_next = 8'(-ip);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            q7_reg   <= q7_next;
            sat7_reg <= sat7_next;
            nan7_reg <= c6_reg.nan;
        end
    end

    assign m_tvalid = valid_reg[NSTG-1];
    assign m_tdata  = q7_reg;
    assign m_tuser  = {nan7_reg, sat7_reg};

endmodule

// ----- test/quantizer_checker.sv -----
// watches the request and result channels of the int8 weight quantizer,
// predicts each result from its own copy of the scale and compares it
// depends on fiq_pkg
`timescale 1ns / 1ps

module quantizer_checker (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      weight_scale_we,
    input  logic [fiq_pkg::FP_W-1:0]  weight_scale_wdata,
    input  logic                      s_tvalid,
    input  logic                      s_tready,
    input  logic [fiq_pkg::FP_W-1:0]  s_tdata,
    input  logic                      m_tvalid,
    input  logic                      m_tready,
    input  logic [fiq_pkg::Q_W-1:0]   m_tdata,
    input  logic [1:0]                m_tuser,
    output int                        fail_count,
    output int                        pending_count
);

    typedef struct packed {
        logic [fiq_pkg::Q_W-1:0] value;
        logic                    sat;
        logic                    nan;
    } quant_t;

    logic [fiq_pkg::FP_W-1:0] scale_bits;
    // predicted results waiting for the block, in request order
    quant_t                   want_mem[4096];
    logic [11:0]              wr_ptr;
    logic [11:0]              rd_ptr;

    // round x / 2^k to nearest even
    function automatic logic [199:0] round_shift(input logic [199:0] x, input int k);
        logic [199:0] q;
        logic [199:0] rem;
        logic [199:0] half;
        if (k <= 0) return x << (-k);
        q    = x >> k;
        rem  = x - (q << k);
        half = 200'd1 << (k - 1);
        if (rem > half || (rem == half && q[0])) q = q + 1;
        return q;
    endfunction

    function automatic int msb_of(input logic [199:0] x);
        int m;
        m = -1;
        for (int i = 0; i < 200; i++) if (x[i]) m = i;
        return m;
    endfunction

    function automatic quant_t quantize(input logic [31:0] w, input logic [31:0] s);
        quant_t       r;
        logic         sign;
        logic [7:0]   ew, es;
        logic [23:0]  mw, ms;
        logic [199:0] prod, mag, sum;
        int           ea, eb, e, m, lsb, k2, ival;
        logic         w_nan, s_nan, w_inf, s_inf, w_zero, s_zero;
        r      = '0;
        sign   = w[31] ^ s[31];
        ew     = w[30:23];
        es     = s[30:23];
        w_nan  = (ew == 8'hff) && (w[22:0] != 0);
        s_nan  = (es == 8'hff) && (s[22:0] != 0);
        w_inf  = (ew == 8'hff) && (w[22:0] == 0);
        s_inf  = (es == 8'hff) && (s[22:0] == 0);
        w_zero = (w[30:0] == 0);
        s_zero = (s[30:0] == 0);
        if (w_nan || s_nan || (w_inf && s_zero) || (s_inf && w_zero)) begin
            r.nan = 1'b1;
            return r;
        end
        if (w_inf || s_inf) begin
            r.sat   = 1'b1;
            r.value = sign ? 8'h80 : 8'h7f;
            return r;
        end
        if (w_zero || s_zero) return r;
        mw   = {ew != 0, w[22:0]};
        ms   = {es != 0, s[22:0]};
        ea   = (ew == 0) ? 1 : int'(ew);
        eb   = (es == 0) ? 1 : int'(es);
        // exact product is prod * 2^e
        prod = 200'(mw) * 200'(ms);
        e    = ea + eb - 300;
        m    = msb_of(prod);
        if (e + m >= 8) begin
            r.sat   = 1'b1;
            r.value = sign ? 8'h80 : 8'h7f;
            return r;
        end
        lsb = e + m - 23;
        if (lsb < -149) lsb = -149;
        // magnitude of the rounded product in units of 2^-151
        mag = round_shift(prod, lsb - e) << (lsb + 151);
        sum = mag + (200'd1 << 150);
        k2  = msb_of(sum) - 23;
        sum = round_shift(sum, k2) << k2;
        if (!sign && sum > (200'd127 << 151)) begin
            r.sat   = 1'b1;
            r.value = 8'h7f;
        end else if (sign && sum > (200'd128 << 151)) begin
            r.sat   = 1'b1;
            r.value = 8'h80;
        end else begin
            ival    = int'(sum >> 151);
            r.value = sign ? 8'(-ival) : 8'(ival);
        end
        return r;
    endfunction

    initial begin
        fail_count    = 0;
        pending_count = 0;
        scale_bits    = fiq_pkg::SCALE_RESET;
        wr_ptr        = '0;
        rd_ptr        = '0;
    end

    // signals only change at rising edges, so the falling edge sees what the next edge takes
    always @(negedge aclk) begin
        quant_t got;
        quant_t want;
        if (!aresetn) begin
            scale_bits = fiq_pkg::SCALE_RESET;
        end else begin
            // a request taken at the write edge still sees the old scale
            if (s_tvalid && s_tready) begin
                want_mem[wr_ptr] = quantize(s_tdata, scale_bits);
                wr_ptr           = wr_ptr + 12'd1;
            end
            if (weight_scale_we) scale_bits = weight_scale_wdata;
            if (m_tvalid && m_tready) begin
                got = {m_tdata, m_tuser[0], m_tuser[1]};
                if (wr_ptr == rd_ptr) begin
                    $display("%0t: unexpected result value=%h sat=%b nan=%b",
                             $time, got.value, got.sat, got.nan);
                    fail_count++;
                end else begin
                    want   = want_mem[rd_ptr];
                    rd_ptr = rd_ptr + 12'd1;
                    if (got != want) begin
                        $display({"%0t: mismatch expected value=%h sat=%b nan=%b,",
                                  " got value=%h sat=%b nan=%b"},
                                 $time, want.value, want.sat, want.nan,
                                 got.value, got.sat, got.nan);
                        fail_count++;
                    end
                end
            end
        end
        pending_count = int'(12'(wr_ptr - rd_ptr));
    end

endmodule

// ----- test/testbench.sv -----
// stimulus and verdict for the int8 weight quantizer: directed weights,
// then random weights under a series of scale settings and stall patterns
// depends on fiq_pkg, fp32_to_int8_weight_quantizer and quantizer_checker
`timescale 1ns / 1ps

module testbench;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      weight_scale_we = 1'b0;
    logic [fiq_pkg::FP_W-1:0]  weight_scale_wdata = '0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [fiq_pkg::FP_W-1:0]  s_tdata = '0;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [fiq_pkg::Q_W-1:0]   m_tdata;   // quantized_value
    logic [1:0]                m_tuser;   // saturated, not_a_number
    int                        fail_count;
    int                        pending_count;
    int                        idle_in = 0;
    int                        idle_out = 0;

    always #2 aclk = ~aclk;

    fp32_to_int8_weight_quantizer u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .weight_scale_we(weight_scale_we), .weight_scale_wdata(weight_scale_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    quantizer_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .weight_scale_we(weight_scale_we), .weight_scale_wdata(weight_scale_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    always @(posedge aclk) m_tready <= ($urandom_range(0, 99) >= idle_out);

    task automatic send_weight(input logic [31:0] w);
        logic taken;
        while ($urandom_range(0, 99) < idle_in) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        do begin
            @(negedge aclk);
            taken = s_tready;
            @(posedge aclk);
        end while (!taken);
    endtask

    // let the pipeline empty before touching the scale
    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending_count != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    task automatic write_scale(input logic [31:0] v);
        drain();
        weight_scale_we    <= 1'b1;
        weight_scale_wdata <= v;
        @(posedge aclk);
        weight_scale_we    <= 1'b0;
    endtask

    function automatic logic [31:0] pick_weight();
        logic [31:0] specials[8];
        specials = '{32'h0, 32'h80000000, 32'h7f800000, 32'hff800000,
                     32'h7fc00000, 32'h00000001, 32'h7f7fffff, 32'h80000001};
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return specials[$urandom_range(0, 7)];
            default: return {1'($urandom_range(0, 1)), 8'($urandom_range(108, 136)),
                             23'($urandom())};
        endcase
    endfunction

    logic [31:0] directed[20] = '{
        32'h00000000, 32'h80000000, 32'h7f800000, 32'hff800000, 32'h7fc00001,
        32'h42fd0000, 32'h42fe0000, 32'h42ff0000, 32'hc3008000, 32'hc2ff0000,
        32'h3f000000, 32'hbf000000, 32'h3fc00000, 32'h40200000, 32'h00000001,
        32'hffffffff, 32'h7f7fffff, 32'h3effffff, 32'hc3000000, 32'h42fe8000
    };
    logic [31:0] scales[12] = '{
        32'h3f800000, 32'h42fe0000, 32'h7f800000, 32'h7fc00001,
        32'h80000000, 32'h00000001, 32'hffffffff, 32'hbf000000,
        32'h0, 32'h0, 32'h3c000000, 32'h7f7fffff
    };

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // reset scale of +0.0 makes infinite weights NaN
        for (int i = 0; i < 5; i++) send_weight(directed[i]);
        for (int p = 0; p < 12; p++) begin
            if (p < 4) begin
                idle_in  = 36;
                idle_out = 72;
            end else if (p < 8) begin
                idle_in  = 72;
                idle_out = 36;
            end else begin
                idle_in  = 0;
                idle_out = 0;
            end
            if (p == 8)
                write_scale({1'($urandom_range(0, 1)), 8'($urandom_range(118, 134)),
                             23'($urandom())});
            else if (p == 9)
                write_scale($urandom());
            else
                write_scale(scales[p]);
            if (p == 0)
                foreach (directed[i]) send_weight(directed[i]);
            for (int i = 0; i < 80; i++) send_weight(pick_weight());
        end
        drain();
        if (fail_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

    initial begin
        #4000000;
        $display("testbench NOT OK");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/fiq_pkg.sv
hdl/fp32_to_int8_weight_quantizer.sv
test/quantizer_checker.sv
test/testbench.sv
